>>> rtl/chained_hash_table_unit_assert.svh
// Assertion macros for the chained hash table unit.
// Used by the checker; needs a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
`define CHAINED_HASH_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define CHT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cht assertion failed");

// next-cycle implication
`define CHT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cht assertion failed");

`endif

>>> rtl/cht_pkg.sv
// Shared types and codes for the chained hash table unit.
// No dependencies.
package cht_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    localparam int BKT_IDX_W = 16;
    localparam logic [8:0] BUCKET_COUNT_RST = 9'd256;

    typedef struct packed {
        logic [1:0]           cmd;
        logic signed [31:0]   key;
        logic [31:0]          value;
        logic [BKT_IDX_W-1:0] bucket;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] value_out;
        logic [10:0] entry_count;
    } t_result;

endpackage

>>> rtl/chained_hash_table_unit.sv
// Top level of the chained hash table unit.
// Depends on cht_pkg, cht_front, cht_queue, cht_back.
//
// Commands enter on the s_axis channel (tuser = cmd, tdata = key, value) and
// one result word per command leaves on m_axis. i_cfg_we/i_cfg_wdata write
// the bucket count; write it only while the unit is idle.
// The front end reduces the key modulo the bucket count (4 quotient bits
// per cycle), then hands it through a two-entry queue to the back end.
// The back end handles an insert or a direct miss in its head step,
// visits a chain node per compare step on lookup and remove, adds an
// unlink step for a removed node, and then loads the output register.
// The front end takes a new command only after it has pushed the last
// one into the queue.
// After reset the back end writes every bucket head empty, one per cycle;
// s_axis_tready stays low until that is done.
// A stalled m_axis holds its result in the output register; the back end
// then waits with its next result, the queue fills and s_axis_tready drops.
module chained_hash_table_unit #(
    parameter int BUCKETS = 256,
    parameter int NODES   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[1:0], found[2], value_out[34:3],
                                        // entry_count[45:35], zero[47:46]
);

    logic               init_done;
    logic               push_valid, push_ready;
    logic               pop_valid, pop_ready;
    cht_pkg::t_cmd_item push_item, pop_item;
    cht_pkg::t_result   result;

    cht_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (init_done),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_key        (s_axis_tdata[31:0]),
        .i_value      (s_axis_tdata[63:32]),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_item       (push_item)
    );

    cht_queue #(.W($bits(cht_pkg::t_cmd_item))) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_item)
    );

    cht_back #(.BUCKETS(BUCKETS), .NODES(NODES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_init_done (init_done),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_item      (pop_item),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {2'b00, result.entry_count, result.value_out,
                           result.found, result.status};

endmodule

>>> rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                           i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                           o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cht_front.sv
// Front end: accepts commands, holds the bucket count register and
// reduces the key to a bucket, 4 bits per cycle. Depends on cht_pkg.
module cht_front #(
    parameter int BUCKETS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_cfg_we,
    input  logic [8:0]          i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_cmd,
    input  logic [31:0]         i_key,
    input  logic [31:0]         i_value,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output cht_pkg::t_cmd_item  o_item
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [8:0]  r_bc;
    logic [2:0]  r_step, n_step;
    logic [1:0]  r_cmd, n_cmd;
    logic [31:0] r_key, n_key;
    logic [31:0] r_value, n_value;
    logic [31:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic [8:0]  r_rem, n_rem;
    logic [8:0]  bce;
    logic [9:0]  acc;
    logic [8:0]  fin;

    always_comb begin
        if (r_bc == 9'd0) begin
            bce = 9'd1;
        end else if (32'(r_bc) > BUCKETS) begin
            bce = 9'(BUCKETS);
        end else begin
            bce = r_bc;
        end
    end

    assign o_ready      = (r_state == F_IDLE) && i_en;
    assign o_push_valid = (r_state == F_PUSH);
    assign fin          = (r_neg && r_rem != 9'd0) ? bce - r_rem : r_rem;

    always_comb begin
        o_item.cmd    = r_cmd;
        o_item.key    = r_key;
        o_item.value  = r_value;
        o_item.bucket = cht_pkg::BKT_IDX_W'(fin);
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_value = r_value;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_rem   = r_rem;
        acc     = '0;
        case (r_state)
            F_IDLE: begin
                if (i_valid && o_ready) begin
                    n_cmd   = i_cmd;
                    n_key   = i_key;
                    n_value = i_value;
                    n_neg   = i_key[31];
                    n_mag   = i_key[31] ? (~i_key + 32'd1) : i_key;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                for (int i = 0; i < 4; i++) begin
                    acc = {n_rem, r_mag[31-i]};
                    if (acc >= {1'b0, bce}) begin
                        acc = acc - {1'b0, bce};
                    end
                    n_rem = acc[8:0];
                end
                n_mag  = {r_mag[27:0], 4'd0};
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_push_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_bc    <= cht_pkg::BUCKET_COUNT_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_bc <= i_cfg_wdata;
            end
        end
        r_step  <= n_step;
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_value <= n_value;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_rem   <= n_rem;
    end

endmodule

>>> rtl/cht_queue.sv
// Two-entry queue between front and back ends.
// No dependencies.
module cht_queue #(
    parameter int W = 82
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  logic [W-1:0] i_push_data,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output logic [W-1:0] o_pop_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr, r_rptr;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

>>> rtl/cht_back.sv
// Back end: clears bucket heads after reset, then executes commands
// against the head and node memories. Depends on cht_pkg, cht_ram.
module cht_back #(
    parameter int BUCKETS = 256,
    parameter int NODES   = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    output logic               o_init_done,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  cht_pkg::t_cmd_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output cht_pkg::t_result   o_result
);

    localparam int NW  = $clog2(NODES + 1);
    localparam int NAW = NODES > 1 ? $clog2(NODES) : 1;
    localparam int BAW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
    localparam logic [NW-1:0]  NIL      = NW'(NODES);
    localparam logic [BAW-1:0] LAST_BKT = BAW'(BUCKETS - 1);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_REM2 = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [BAW-1:0]   r_init_cnt, n_init_cnt;
    logic [1:0]       r_cmd, n_cmd;
    logic [31:0]      r_key, n_key;
    logic [31:0]      r_value, n_value;
    logic [BAW-1:0]   r_bkt, n_bkt;
    logic [NW-1:0]    r_cur, n_cur;
    logic [NW-1:0]    r_prev, n_prev;
    logic [NW-1:0]    r_free, n_free;
    logic [NW-1:0]    r_fresh, n_fresh;
    logic [NW-1:0]    r_count, n_count;
    cht_pkg::t_result r_res, n_res;
    cht_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             head_we;
    logic [BAW-1:0]   head_waddr, head_raddr;
    logic [NW-1:0]    head_wdata, head_rd;
    logic             kv_we;
    logic [NAW-1:0]   kv_waddr, node_raddr;
    logic [31:0]      key_rd, val_rd;
    logic             link_we;
    logic [NAW-1:0]   link_waddr;
    logic [NW-1:0]    link_wdata, link_rd;
    logic [NW-1:0]    alloc;

    cht_ram #(.W(NW), .DEPTH(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rd)
    );
    cht_ram #(.W(32), .DEPTH(NODES)) u_key (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(kv_waddr), .i_wdata(r_key),
        .i_raddr(node_raddr), .o_rdata(key_rd)
    );
    cht_ram #(.W(32), .DEPTH(NODES)) u_val (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(kv_waddr), .i_wdata(r_value),
        .i_raddr(node_raddr), .o_rdata(val_rd)
    );
    cht_ram #(.W(NW), .DEPTH(NODES)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(node_raddr), .o_rdata(link_rd)
    );

    assign o_init_done = (r_state != S_INIT);
    assign o_pop_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;
    assign alloc       = (r_free < NIL) ? r_free : r_fresh;

    always_comb begin
        n_state     = r_state;
        n_init_cnt  = r_init_cnt;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_value     = r_value;
        n_bkt       = r_bkt;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_free      = r_free;
        n_fresh     = r_fresh;
        n_count     = r_count;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        head_we     = 1'b0;
        head_waddr  = r_bkt;
        head_wdata  = NIL;
        head_raddr  = i_item.bucket[BAW-1:0];
        kv_we       = 1'b0;
        kv_waddr    = alloc[NAW-1:0];
        node_raddr  = r_free[NAW-1:0];
        link_we     = 1'b0;
        link_waddr  = alloc[NAW-1:0];
        link_wdata  = head_rd;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                head_we    = 1'b1;
                head_waddr = r_init_cnt;
                n_init_cnt = r_init_cnt + BAW'(1);
                if (r_init_cnt == LAST_BKT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_cmd   = i_item.cmd;
                    n_key   = i_item.key;
                    n_value = i_item.value;
                    n_bkt   = i_item.bucket[BAW-1:0];
                    n_prev  = NIL;
                    n_res   = '{status: cht_pkg::ST_OK, found: 1'b0,
                                value_out: 32'd0, entry_count: 11'd0};
                    case (i_item.cmd)
                        cht_pkg::CMD_INSERT: begin
                            if (i_item.value == 32'd0) begin
                                n_res.status = cht_pkg::ST_ZERO;
                                n_state      = S_DONE;
                            end else if (r_free >= NIL && r_fresh >= NIL) begin
                                n_res.status = cht_pkg::ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_HEAD;
                            end
                        end
                        cht_pkg::CMD_LOOKUP, cht_pkg::CMD_REMOVE: begin
                            n_state = S_HEAD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_HEAD: begin
                if (r_cmd == cht_pkg::CMD_INSERT) begin
                    kv_we      = 1'b1;
                    link_we    = 1'b1;
                    head_we    = 1'b1;
                    head_wdata = alloc;
                    if (r_free < NIL) begin
                        n_free = link_rd;
                    end else begin
                        n_fresh = r_fresh + NW'(1);
                    end
                    n_count = r_count + NW'(1);
                    n_state = S_DONE;
                end else if (head_rd >= NIL) begin
                    n_res.status = cht_pkg::ST_MISS;
                    n_state      = S_DONE;
                end else begin
                    n_cur      = head_rd;
                    node_raddr = head_rd[NAW-1:0];
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                if (key_rd == r_key) begin
                    n_res.found = 1'b1;
                    if (r_cmd == cht_pkg::CMD_LOOKUP) begin
                        n_res.value_out = val_rd;
                        n_state         = S_DONE;
                    end else begin
                        if (r_prev >= NIL) begin
                            head_we    = 1'b1;
                            head_wdata = link_rd;
                        end else begin
                            link_we    = 1'b1;
                            link_waddr = r_prev[NAW-1:0];
                            link_wdata = link_rd;
                        end
                        n_state = S_REM2;
                    end
                end else begin
                    n_prev = r_cur;
                    if (link_rd >= NIL) begin
                        n_res.status = cht_pkg::ST_MISS;
                        n_state      = S_DONE;
                    end else begin
                        n_cur      = link_rd;
                        node_raddr = link_rd[NAW-1:0];
                    end
                end
            end
            S_REM2: begin
                link_we    = 1'b1;
                link_waddr = r_cur[NAW-1:0];
                link_wdata = r_free;
                n_free     = r_cur;
                if (r_count != '0) begin
                    n_count = r_count - NW'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out             = r_res;
                    n_out.entry_count = 11'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_cnt  <= '0;
            r_free      <= NIL;
            r_fresh     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_cnt  <= n_init_cnt;
            r_free      <= n_free;
            r_fresh     <= n_fresh;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_value <= n_value;
        r_bkt   <= n_bkt;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

>>> rtl/cht_checker.sv
// Port-level checks for the chained hash table unit, bound to its top level.
// Depends on cht_pkg and chained_hash_table_unit_assert.svh.
`include "chained_hash_table_unit_assert.svh"

module cht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    `CHT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CHT_ASSERT_NEXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CHT_ASSERT_IMPL(a_found_ok, m_axis_tvalid && m_axis_tdata[2],
                     m_axis_tdata[1:0] == cht_pkg::ST_OK)
    `CHT_ASSERT_IMPL(a_value_hit, m_axis_tvalid && m_axis_tdata[34:3] != 32'd0,
                     m_axis_tdata[2])
    `CHT_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[47:46] == 2'b00)

endmodule

bind chained_hash_table_unit cht_checker u_cht_checker (.*);

>>> dv/tb_chained_hash_table_unit.sv
// Self-checking testbench for the chained hash table unit.
// Drives commands over s_axis, predicts each result word and checks m_axis.
// Depends on cht_pkg and chained_hash_table_unit.
module tb_chained_hash_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT = 256;
    localparam int NPOOL = 1024;
    localparam int NIL = NPOOL;
    localparam int WDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    chained_hash_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // shadow table
    int unsigned nbkt_cfg;
    int          head_of[NBKT];
    logic [31:0] nkey[NPOOL];
    logic [31:0] nval[NPOOL];
    int          nlink[NPOOL];
    int          free_list;
    int          fresh_cnt;
    int          stored;

    cht_pkg::t_result expected_q[$];
    int      mismatches = 0;
    int      wdog = 0;
    bit      timed_out = 0;
    bit      sink_hold = 0;
    logic [31:0] keys_seen[$];

    function automatic int bucket_for(logic [31:0] k);
        longint sk, r, bc;
        bc = (nbkt_cfg == 0) ? 1 : (nbkt_cfg > NBKT ? NBKT : nbkt_cfg);
        sk = longint'($signed(k));
        r = sk % bc;
        if (r < 0) r += bc;
        return int'(r);
    endfunction

    function automatic cht_pkg::t_result table_apply(logic [1:0] cmd, logic [31:0] k,
                                                     logic [31:0] v);
        cht_pkg::t_result r;
        int b, n, prev, steps;
        r = '0;
        b = bucket_for(k);
        if (cmd == cht_pkg::CMD_INSERT) begin
            if (v == 0) begin
                r.status = cht_pkg::ST_ZERO;
            end else begin
                if (free_list != NIL) begin
                    n = free_list;
                    free_list = nlink[n];
                end else if (fresh_cnt < NPOOL) begin
                    n = fresh_cnt;
                    fresh_cnt++;
                end else begin
                    n = NIL;
                end
                if (n == NIL) begin
                    r.status = cht_pkg::ST_FULL;
                end else begin
                    nkey[n] = k;
                    nval[n] = v;
                    nlink[n] = head_of[b];
                    head_of[b] = n;
                    stored++;
                end
            end
        end else if (cmd == cht_pkg::CMD_LOOKUP || cmd == cht_pkg::CMD_REMOVE) begin
            r.status = cht_pkg::ST_MISS;
            prev = NIL;
            n = head_of[b];
            for (steps = 0; n < NIL && steps < NPOOL; steps++) begin
                if (nkey[n] == k) begin
                    r.status = cht_pkg::ST_OK;
                    r.found = 1'b1;
                    if (cmd == cht_pkg::CMD_LOOKUP) begin
                        r.value_out = nval[n];
                    end else begin
                        if (prev == NIL) head_of[b] = nlink[n];
                        else nlink[prev] = nlink[n];
                        nlink[n] = free_list;
                        free_list = n;
                        if (stored > 0) stored--;
                    end
                    break;
                end
                prev = n;
                n = nlink[n];
            end
        end
        r.entry_count = 11'(stored);
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // watchdog: cycles with no accepted word
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("tb_chained_hash_table_unit failed");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        cht_pkg::t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[1:0];
            got.found = m_axis_tdata[2];
            got.value_out = m_axis_tdata[34:3];
            got.entry_count = m_axis_tdata[45:35];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
            end else begin
                want = expected_q.pop_front();
                if (got !== want || m_axis_tdata[47:46] !== 2'b00) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d f=%0d v=%h n=%0d got st=%0d f=%0d v=%h n=%0d",
                                 want.status, want.found, want.value_out, want.entry_count,
                                 got.status, got.found, got.value_out, got.entry_count);
                end
            end
        end
    end

    // sink backpressure
    always @(posedge i_clk) begin
        int g;
        if (!m_axis_tready || (m_axis_tvalid && m_axis_tready)) begin
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
            end else begin
                g = gap_len();
                m_axis_tready <= (g == 0) || ($urandom_range(0, 2) == 0);
            end
        end
    end

    task automatic send_cmd(logic [1:0] cmd, logic [31:0] k, logic [31:0] v, bit has_exp,
                            cht_pkg::t_result exp_r);
        cht_pkg::t_result r;
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {v, k};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = table_apply(cmd, k, v);
        if (has_exp) expected_q.push_back(exp_r);
        else expected_q.push_back(r);
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_buckets(logic [8:0] bc);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= bc;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        nbkt_cfg = bc;
    endtask

    function automatic logic [31:0] pick_key();
        int p;
        p = $urandom_range(0, 9);
        if (keys_seen.size() > 0 && p < 6) return keys_seen[$urandom_range(0, keys_seen.size() - 1)];
        if (p < 8) return 32'($signed($urandom_range(0, 40)) - 20);
        return $urandom;
    endfunction

    task automatic random_phase(int count, int ins_pct);
        logic [1:0] cmd;
        logic [31:0] k, v;
        int p;
        cht_pkg::t_result none;
        none = '0;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(0, 99);
            if (p < ins_pct) cmd = cht_pkg::CMD_INSERT;
            else if (p < ins_pct + (100 - ins_pct) / 2) cmd = cht_pkg::CMD_LOOKUP;
            else if (p < 97) cmd = cht_pkg::CMD_REMOVE;
            else cmd = cht_pkg::CMD_NOP;
            k = pick_key();
            v = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
            if ($urandom_range(0, 29) == 0) v = 32'hFFFF_FFFF;
            if (cmd == cht_pkg::CMD_INSERT && keys_seen.size() < 64) keys_seen.push_back(k);
            send_cmd(cmd, k, v, 0, none);
        end
    endtask

    typedef struct {
        logic [1:0]       cmd;
        logic [31:0]      k;
        logic [31:0]      v;
        bit               chk;
        cht_pkg::t_result r;
    } t_row;

    t_row rows[$];

    initial begin
        for (int i = 0; i < NBKT; i++) head_of[i] = NIL;
        free_list = NIL;
        fresh_cnt = 0;
        stored = 0;
        nbkt_cfg = 256;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            '{cht_pkg::CMD_LOOKUP, 32'd5, 32'd0, 1,
              '{cht_pkg::ST_MISS, 1'b0, 32'd0, 11'd0}},
            '{cht_pkg::CMD_REMOVE, 32'h8000_0000, 32'd0, 1,
              '{cht_pkg::ST_MISS, 1'b0, 32'd0, 11'd0}},
            '{cht_pkg::CMD_INSERT, 32'd7, 32'd0, 1,
              '{cht_pkg::ST_ZERO, 1'b0, 32'd0, 11'd0}},
            '{cht_pkg::CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1,
              '{cht_pkg::ST_OK, 1'b0, 32'd0, 11'd1}},
            '{cht_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'd1, 1,
              '{cht_pkg::ST_OK, 1'b0, 32'd0, 11'd2}},
            '{cht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 1,
              '{cht_pkg::ST_OK, 1'b0, 32'd0, 11'd3}},
            '{cht_pkg::CMD_LOOKUP, 32'h8000_0000, 32'd0, 1,
              '{cht_pkg::ST_OK, 1'b1, 32'hFFFF_FFFF, 11'd3}},
            '{cht_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1,
              '{cht_pkg::ST_OK, 1'b1, 32'd1, 11'd3}},
            '{cht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hAAAA_5555, 0,
              '{cht_pkg::ST_OK, 1'b0, 32'd0, 11'd0}},
            '{cht_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1,
              '{cht_pkg::ST_OK, 1'b1, 32'hAAAA_5555, 11'd4}},
            '{cht_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'd0, 1,
              '{cht_pkg::ST_OK, 1'b1, 32'd0, 11'd3}},
            '{cht_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1,
              '{cht_pkg::ST_OK, 1'b1, 32'h1234_5678, 11'd3}},
            '{cht_pkg::CMD_NOP, 32'd1, 32'd9, 1,
              '{cht_pkg::ST_OK, 1'b0, 32'd0, 11'd3}},
            '{cht_pkg::CMD_INSERT, 32'd255, 32'd3, 0,
              '{cht_pkg::ST_OK, 1'b0, 32'd0, 11'd0}},
            '{cht_pkg::CMD_INSERT, 32'hFFFF_FF01, 32'd4, 0,
              '{cht_pkg::ST_OK, 1'b0, 32'd0, 11'd0}},
            '{cht_pkg::CMD_REMOVE, 32'd255, 32'd0, 0,
              '{cht_pkg::ST_OK, 1'b0, 32'd0, 11'd0}},
            '{cht_pkg::CMD_LOOKUP, 32'hFFFF_FF01, 32'd0, 0,
              '{cht_pkg::ST_OK, 1'b0, 32'd0, 11'd0}}
        };
        foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].k, rows[i].v, rows[i].chk, rows[i].r);

        // one bucket: every key in a single chain; stale entries stay counted
        set_buckets(9'd1);
        random_phase(80, 45);
        set_buckets(9'd0);
        random_phase(30, 40);
        set_buckets(9'd7);
        random_phase(120, 45);
        // hold the sender until everything is back
        drain();
        set_buckets(9'd511);
        random_phase(80, 40);
        set_buckets(9'd256);
        random_phase(100, 40);

        // fill the pool, hit full, then free some
        set_buckets(9'd200);
        keys_seen.delete();
        while (fresh_cnt < NPOOL || free_list != NIL) begin
            send_cmd(cht_pkg::CMD_INSERT, $urandom, $urandom | 32'd1, 0, '0);
        end
        for (int i = 0; i < 10; i++)
            send_cmd(cht_pkg::CMD_INSERT, $urandom, $urandom | 32'd1, 0, '0);
        random_phase(150, 30);

        // output stall with full input queue
        sink_hold = 1;
        fork
            begin random_phase(6, 50); s_axis_tvalid <= 1'b0; end
            begin repeat (200) @(posedge i_clk); sink_hold = 0; end
        join
        set_buckets(9'd3);
        random_phase(200, 50);

        drain();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb_chained_hash_table_unit passed");
        end else begin
            $display("tb_chained_hash_table_unit failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/cht_pkg.sv
rtl/cht_ram.sv
rtl/cht_front.sv
rtl/cht_queue.sv
rtl/cht_back.sv
rtl/chained_hash_table_unit.sv
rtl/cht_checker.sv
dv/tb_chained_hash_table_unit.sv
